@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of the note expiry table.
// Depends on nothing; each macro expects a clock, an active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NET_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NET_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/core/net_pkg.sv @@
// Types and constants shared by the note expiry table modules.
// Depends on nothing.
package net_pkg;

  localparam int CH_W   = 4;
  localparam int TONE_W = 6;
  localparam int VEL_W  = 7;
  localparam int TIME_W = 63;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_START    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STOP     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRE   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_STOP_ALL = 2'd3;

  localparam logic MSG_ON  = 1'b0;
  localparam logic MSG_OFF = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [TIME_W-1:0] end_time;
  } entry_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CH_W-1:0]   channel;
    logic [TONE_W-1:0] tone;
    logic [VEL_W-1:0]  velocity;
    logic [TIME_W-1:0] stop_time;
    logic [TIME_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic              message;
    logic [CH_W-1:0]   channel;
    logic [TONE_W-1:0] tone;
    logic [VEL_W-1:0]  velocity;
    logic              expired;
    logic              last;
  } out_item_t;

endpackage

@@ rtl/core/net_mem.sv @@
// Entry memory of the note expiry table: channel and stop time per tone.
// One write port and one read port with registered read data; uses net_pkg.
module net_mem #(
  parameter int NUM_TONES = 64,
  parameter int IDX_W     = 6
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  net_pkg::entry_t      wr_data,
  input  logic [IDX_W-1:0]     rd_addr,
  output net_pkg::entry_t      rd_data
);

  net_pkg::entry_t mem [NUM_TONES];
  net_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/net_ctrl.sv @@
// Sequencer of the note expiry table: playing flags, lookups, sweeps and the output register.
// Drives the net_mem ports; uses net_pkg.
module net_ctrl #(
  parameter int NUM_TONES = 64,
  parameter int IDX_W     = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  net_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output net_pkg::out_item_t   out_item,
  output logic                 wr_en,
  output logic [IDX_W-1:0]     wr_addr,
  output net_pkg::entry_t      wr_data,
  output logic [IDX_W-1:0]     rd_addr,
  input  net_pkg::entry_t      rd_data
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOOK  = 5'b00010,
    ST_ON    = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TONES - 1);

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [NUM_TONES-1:0] flags_r, flags_nxt;
  net_pkg::in_item_t    item_r;
  net_pkg::out_item_t   pend_r, pend_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic                 out_valid_r;
  net_pkg::out_item_t   out_item_r;

  logic                 accept;
  logic                 slot_free;
  logic                 emit;
  net_pkg::out_item_t   emit_item;
  logic                 tone_ok;
  logic                 is_tone_op;
  logic [IDX_W-1:0]     in_idx;
  logic                 playing;
  logic                 hit;
  logic                 at_end;
  logic                 time_due;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign slot_free  = !out_valid_r || out_ready;
  assign tone_ok    = 32'(in_item.tone) < NUM_TONES;
  assign is_tone_op = (in_item.kind == net_pkg::KIND_START) ||
                      (in_item.kind == net_pkg::KIND_STOP);
  assign in_idx     = IDX_W'(in_item.tone);
  assign playing    = flags_r[idx_r];
  assign time_due   = item_r.now_time >= rd_data.end_time;
  assign hit        = playing && ((item_r.kind == net_pkg::KIND_STOP_ALL) || time_due);
  assign at_end     = (idx_r == LAST_IDX);

  assign wr_addr = idx_r;
  assign wr_data = '{channel: item_r.channel, end_time: item_r.stop_time};

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    flags_nxt      = flags_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    rd_addr        = idx_r;
    wr_en          = 1'b0;
    emit           = 1'b0;
    emit_item      = pend_r;
    case (state_r)
      ST_IDLE: begin
        rd_addr = (is_tone_op && tone_ok) ? in_idx : '0;
        if (accept) begin
          pend_valid_nxt = 1'b0;
          if (is_tone_op) begin
            idx_nxt   = tone_ok ? in_idx : '0;
            state_nxt = tone_ok ? ST_LOOK : ST_IDLE;
          end else begin
            idx_nxt   = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_LOOK: begin
        emit_item = '{message: net_pkg::MSG_OFF, channel: rd_data.channel,
                      tone: net_pkg::TONE_W'(idx_r), velocity: '0, expired: 1'b0,
                      last: (item_r.kind == net_pkg::KIND_STOP)};
        if (!playing) begin
          state_nxt = (item_r.kind == net_pkg::KIND_START) ? ST_ON : ST_IDLE;
        end else if (slot_free) begin
          emit = 1'b1;
          if (item_r.kind == net_pkg::KIND_START) begin
            state_nxt = ST_ON;
          end else begin
            flags_nxt[idx_r] = 1'b0;
            state_nxt        = ST_IDLE;
          end
        end
      end
      ST_ON: begin
        emit_item = '{message: net_pkg::MSG_ON, channel: item_r.channel,
                      tone: net_pkg::TONE_W'(idx_r), velocity: item_r.velocity,
                      expired: 1'b0, last: 1'b1};
        if (slot_free) begin
          emit             = 1'b1;
          wr_en            = 1'b1;
          flags_nxt[idx_r] = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!(hit && pend_valid_r && !slot_free)) begin
          if (hit) begin
            emit             = pend_valid_r;
            pend_valid_nxt   = 1'b1;
            flags_nxt[idx_r] = 1'b0;
            pend_nxt = '{message: net_pkg::MSG_OFF, channel: rd_data.channel,
                         tone: net_pkg::TONE_W'(idx_r), velocity: '0,
                         expired: (item_r.kind == net_pkg::KIND_EXPIRE), last: 1'b0};
          end
          if (at_end) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt = IDX_W'(idx_r + 1'b1);
            rd_addr = IDX_W'(idx_r + 1'b1);
          end
        end
      end
      ST_FLUSH: begin
        emit_item      = pend_r;
        emit_item.last = 1'b1;
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          emit           = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      flags_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      flags_r      <= flags_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pend_r <= pend_nxt;
    if (accept) begin
      item_r <= in_item;
    end
    if (emit) begin
      out_item_r <= emit_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/core/note_expiry_table_core.sv @@
// Top level of the note expiry table: stream ports, entry memory and sequencer.
// Instantiates net_mem and net_ctrl; uses net_pkg.
//
// The input channel takes one command item at a time: note start, note stop, expire
// check or stop all, selected by in_tuser. The output channel carries note-on and
// note-off items; out_tlast marks the final item caused by one command, and a command
// that causes nothing gives no output item at all.
// A note start looks up its tone, shows the note-off for the old channel when the tone
// was playing, then shows its note-on and writes the entry; the next command is then
// taken either way. A note stop looks up its tone, shows its note-off and then takes
// the next command. An expire check or a stop all walks the entry memory one tone per
// cycle while no found note-off has to wait for the output register; its final note-off
// shows after the walk, then the next command is taken. The single read port sets that pace.
// in_tready is high only between commands, so one command is worked on at a time.
// Results pass through one output register. While it is full and out_tready is low it
// holds its item, and the sequencer waits where it must emit; a sweep keeps one found
// note-off in hand so that tlast can be set on the final one.
// Synchronous reset clears all playing flags at once; channels and stop times are
// read only for playing tones and need no clearing.
module note_expiry_table_core #(
  parameter int NUM_TONES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,   // channel, tone, velocity, stop_time, now_time, pad
  input  logic [1:0]   in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,  // channel, tone, velocity, pad
  output logic [1:0]   out_tuser,  // message, expired
  output logic         out_tlast
);

  localparam int IDX_W = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;

  net_pkg::in_item_t  in_item;
  net_pkg::out_item_t out_item;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   rd_addr;
  net_pkg::entry_t    wr_data;
  net_pkg::entry_t    rd_data;

  assign in_item.kind      = in_tuser;
  assign in_item.channel   = in_tdata[3:0];
  assign in_item.tone      = in_tdata[9:4];
  assign in_item.velocity  = in_tdata[16:10];
  assign in_item.stop_time = in_tdata[79:17];
  assign in_item.now_time  = in_tdata[142:80];

  net_mem #(
    .NUM_TONES (NUM_TONES),
    .IDX_W     (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  net_ctrl #(
    .NUM_TONES (NUM_TONES),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  assign out_tdata = {7'd0, out_item.velocity, out_item.tone, out_item.channel};
  assign out_tuser = {out_item.expired, out_item.message};
  assign out_tlast = out_item.last;

endmodule

@@ rtl/core/net_checker.sv @@
// Port checker for the note expiry table, bound to note_expiry_table_core.
// Uses assert_macros.svh and net_pkg.
`include "assert_macros.svh"

module net_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [143:0] in_tdata,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [23:0]  out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);

  logic out_stall;
  logic is_on;
  logic is_off;

  assign out_stall = out_tvalid && !out_tready;
  assign is_on     = out_tvalid && (out_tuser[0] == net_pkg::MSG_ON);
  assign is_off    = out_tvalid && (out_tuser[0] == net_pkg::MSG_OFF);

  `NET_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall,
                  out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
  `NET_ASSERT_IMP(a_on_is_last, clk, rst_n, is_on, out_tlast && !out_tuser[1])
  `NET_ASSERT_IMP(a_off_no_vel, clk, rst_n, is_off, out_tdata[16:10] == 7'd0)
  `NET_ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[23:17] == 7'd0)

endmodule

bind note_expiry_table_core net_checker u_net_checker (.*);

@@ verif/tb_note_expiry_table_core.sv @@
// Self-checking testbench for note_expiry_table_core: directed table, random, fill and sweep.
// A predictor of the tone table and a queue of expected note messages check every output item.
// Depends on net_pkg and the RTL of note_expiry_table_core.
module tb_note_expiry_table_core;

  localparam int NUM_TONES = 64;
  localparam logic [net_pkg::TIME_W-1:0] T_MAX = {net_pkg::TIME_W{1'b1}};

  typedef struct {
    logic [net_pkg::KIND_W-1:0] kind;
    logic [net_pkg::CH_W-1:0]   ch;
    logic [net_pkg::TONE_W-1:0] tone;
    logic [net_pkg::VEL_W-1:0]  vel;
    logic [net_pkg::TIME_W-1:0] stop;
    logic [net_pkg::TIME_W-1:0] now;
    int                         exp_n;
    net_pkg::out_item_t         exp0;
    net_pkg::out_item_t         exp1;
  } cue_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [23:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  bit                         tone_on   [NUM_TONES];
  logic [net_pkg::CH_W-1:0]   tone_chan [NUM_TONES];
  logic [net_pkg::TIME_W-1:0] tone_end  [NUM_TONES];
  net_pkg::out_item_t         pending_msgs[$];
  net_pkg::out_item_t         want;
  int                         mismatch_count = 0;
  int                         src_idle_pct = 0;
  int                         snk_idle_pct = 0;
  bit                         hold_req = 1'b0;
  int                         hold_left = 0;
  logic [net_pkg::TIME_W-1:0] clock_us = '0;

  // A row with exp_n of -1 is checked against the predictor only.
  cue_t dir_cues [22] = '{
    '{net_pkg::KIND_STOP,     0,  0,   0, 0,       0,     0, '0, '0},
    '{net_pkg::KIND_EXPIRE,   0,  0,   0, 0,       T_MAX, 0, '0, '0},
    '{net_pkg::KIND_STOP_ALL, 0,  0,   0, 0,       0,     0, '0, '0},
    '{net_pkg::KIND_START,    0,  0,   0, 0,       0,     1,
      '{net_pkg::MSG_ON, 0, 0, 0, 0, 1}, '0},
    '{net_pkg::KIND_START,    15, 63, 127, T_MAX,  0,     1,
      '{net_pkg::MSG_ON, 15, 63, 127, 0, 1}, '0},
    '{net_pkg::KIND_EXPIRE,   0,  0,   0, 0,       0,     1,
      '{net_pkg::MSG_OFF, 0, 0, 0, 1, 1}, '0},
    '{net_pkg::KIND_START,    5,  0,   1, 100,     T_MAX, -1, '0, '0},
    '{net_pkg::KIND_START,    9,  0,  64, 50,      0,     2,
      '{net_pkg::MSG_OFF, 5, 0, 0, 0, 0}, '{net_pkg::MSG_ON, 9, 0, 64, 0, 1}},
    '{net_pkg::KIND_EXPIRE,   0,  0,   0, 0,       49,    -1, '0, '0},
    '{net_pkg::KIND_EXPIRE,   0,  0,   0, 0,       50,    -1, '0, '0},
    '{net_pkg::KIND_START,    3,  31, 100, T_MAX - 1, 0,  -1, '0, '0},
    '{net_pkg::KIND_EXPIRE,   0,  0,   0, 0,       T_MAX - 1, -1, '0, '0},
    '{net_pkg::KIND_EXPIRE,   0,  0,   0, 0,       T_MAX, -1, '0, '0},
    '{net_pkg::KIND_START,    1,  1,  10, 7,       0,     -1, '0, '0},
    '{net_pkg::KIND_START,    10, 32, 20, 8,       0,     -1, '0, '0},
    '{net_pkg::KIND_START,    14, 62, 30, 9,       0,     -1, '0, '0},
    '{net_pkg::KIND_STOP,     0,  32,  0, 0,       0,     -1, '0, '0},
    '{net_pkg::KIND_STOP,     0,  32,  0, 0,       0,     -1, '0, '0},
    '{net_pkg::KIND_EXPIRE,   0,  0,   0, 0,       6,     -1, '0, '0},
    '{net_pkg::KIND_STOP_ALL, 0,  0,   0, 0,       0,     -1, '0, '0},
    '{net_pkg::KIND_STOP_ALL, 0,  0,   0, 0,       0,     0, '0, '0},
    '{net_pkg::KIND_STOP,     0,  63,  0, 0,       0,     -1, '0, '0}
  };

  note_expiry_table_core #(
    .NUM_TONES(NUM_TONES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic void predict_notes(input net_pkg::in_item_t c,
                                        output net_pkg::out_item_t res[$]);
    net_pkg::out_item_t m;
    res = {};
    case (c.kind)
      net_pkg::KIND_START: begin
        if (tone_on[c.tone]) begin
          m = '{net_pkg::MSG_OFF, tone_chan[c.tone], c.tone, 7'd0, 1'b0, 1'b0};
          res.push_back(m);
        end
        m = '{net_pkg::MSG_ON, c.channel, c.tone, c.velocity, 1'b0, 1'b0};
        res.push_back(m);
        tone_on[c.tone] = 1'b1;
        tone_chan[c.tone] = c.channel;
        tone_end[c.tone] = c.stop_time;
      end
      net_pkg::KIND_STOP: begin
        if (tone_on[c.tone]) begin
          tone_on[c.tone] = 1'b0;
          m = '{net_pkg::MSG_OFF, tone_chan[c.tone], c.tone, 7'd0, 1'b0, 1'b0};
          res.push_back(m);
        end
      end
      default: begin
        for (int t = 0; t < NUM_TONES; t++) begin
          if (tone_on[t] && (c.kind == net_pkg::KIND_STOP_ALL ||
                             c.now_time >= tone_end[t])) begin
            tone_on[t] = 1'b0;
            m = '{net_pkg::MSG_OFF, tone_chan[t], net_pkg::TONE_W'(t), 7'd0,
                  c.kind == net_pkg::KIND_EXPIRE, 1'b0};
            res.push_back(m);
          end
        end
      end
    endcase
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
  endfunction

  // Offers one command, waits for acceptance, then queues its expected note messages.
  task automatic send_cmd(input net_pkg::in_item_t c, input int exp_n,
                          input net_pkg::out_item_t e0, input net_pkg::out_item_t e1);
    net_pkg::out_item_t res[$];
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.kind;
    in_tdata  <= {1'b0, c.now_time, c.stop_time, c.velocity, c.tone, c.channel};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_notes(c, res);
    if (exp_n < 0) begin
      foreach (res[i]) pending_msgs.push_back(res[i]);
    end else begin
      if (exp_n >= 1) pending_msgs.push_back(e0);
      if (exp_n >= 2) pending_msgs.push_back(e1);
    end
  endtask

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_msgs.size() == 0) begin
        $error("output item with no expected note message waiting");
        mismatch_count++;
      end else begin
        want = pending_msgs.pop_front();
        check_field("message", want.message, out_tuser[0]);
        check_field("out_channel", want.channel, out_tdata[3:0]);
        check_field("out_tone", want.tone, out_tdata[9:4]);
        check_field("out_velocity", want.velocity, out_tdata[16:10]);
        check_field("expired", want.expired, out_tuser[1]);
        check_field("last", want.last, out_tlast);
      end
    end
  end

  initial begin
    #(12 * 400000);
    $display("note_expiry_table_core test failed");
    $finish;
  end

  initial begin
    net_pkg::in_item_t c;
    logic [63:0]       wide_bits;
    int                r;
    bit                wide;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 32;
    snk_idle_pct = 72;
    foreach (dir_cues[i]) begin
      c = '{dir_cues[i].kind, dir_cues[i].ch, dir_cues[i].tone, dir_cues[i].vel,
            dir_cues[i].stop, dir_cues[i].now};
      send_cmd(c, dir_cues[i].exp_n, dir_cues[i].exp0, dir_cues[i].exp1);
    end

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 72 : 0;
      snk_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 32 : 0;
      for (int k = 0; k < 15; k++) begin
        r = $urandom_range(99);
        wide = ($urandom_range(7) == 0);
        c.kind = (r < 45) ? net_pkg::KIND_START : (r < 65) ? net_pkg::KIND_STOP :
                 (r < 85) ? net_pkg::KIND_EXPIRE : net_pkg::KIND_STOP_ALL;
        c.channel = net_pkg::CH_W'($urandom_range(15));
        c.tone = ($urandom_range(9) < 7) ? net_pkg::TONE_W'($urandom_range(15)) :
                                           net_pkg::TONE_W'($urandom_range(63));
        c.velocity = net_pkg::VEL_W'($urandom_range(127));
        clock_us = clock_us + $urandom_range(400);
        wide_bits = {$urandom, $urandom};
        c.stop_time = wide ? wide_bits[62:0] : clock_us + $urandom_range(2000);
        wide_bits = {$urandom, $urandom};
        c.now_time = wide ? wide_bits[62:0] : clock_us;
        send_cmd(c, -1, '0, '0);
      end
    end

    // Fill every tone, starting while the output is held off, then expire them all in one sweep.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_req = 1'b1;
    for (int t = 0; t < NUM_TONES; t++) begin
      c = '{net_pkg::KIND_START, net_pkg::CH_W'($urandom_range(15)), net_pkg::TONE_W'(t),
            net_pkg::VEL_W'($urandom_range(127)), clock_us + $urandom_range(2000), '0};
      send_cmd(c, -1, '0, '0);
    end
    c = '{net_pkg::KIND_EXPIRE, '0, '0, '0, '0, T_MAX};
    send_cmd(c, -1, '0, '0);
    in_tvalid <= 1'b0;

    while (pending_msgs.size() != 0) @(posedge clk);
    repeat (NUM_TONES + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("note_expiry_table_core test passed");
    end else begin
      $display("note_expiry_table_core test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/net_pkg.sv
rtl/core/net_mem.sv
rtl/core/net_ctrl.sv
rtl/core/note_expiry_table_core.sv
rtl/core/net_checker.sv
verif/tb_note_expiry_table_core.sv
